### src/lqs_pkg.sv
`default_nettype none
// Shared types and codes for the linear queue with shift unit.
// No dependencies; imported by every module of the block.

package lqs_pkg;

    // Action codes on the item channel
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_PRINT  = 2'd2;
    localparam logic [1:0] ACT_WRONG  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_SHIFTED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_DELETED = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_PRINT   = 3'd5;
    localparam logic [2:0] ST_NOPRINT = 3'd6;
    localparam logic [2:0] ST_WRONG   = 3'd7;

    // Read address sources
    localparam logic [1:0] RD_HEAD     = 2'd0;
    localparam logic [1:0] RD_PTR      = 2'd1;
    localparam logic [1:0] RD_HEAD_PTR = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] item_id;
        logic [63:0]        item_payload;
    } lqs_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_id;
        logic [63:0]        out_payload;
        logic               last;
    } lqs_result_t;

    // Controller -> datapath
    typedef struct packed {
        logic       take;        // capture the item
        logic       rd_en;       // registered memory read
        logic [1:0] rd_src;      // read address source
        logic       wr_tail;     // append captured item at tail, tail+1
        logic       wr_ptr;      // write read data at ptr (compaction)
        logic       ptr_clr;
        logic       ptr_head;    // ptr <= head
        logic       ptr_inc;
        logic       compact;     // tail <= tail-head, head <= 0
        logic       head_inc;
        logic       out_load;    // load result register
        logic       out_mem;     // result data from read data, else zero
        logic       out_last_ptr;// last from ptr position, else 1
        logic [2:0] out_status;
    } lqs_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic       empty;
        logic       tail_full;
        logic       head_zero;
        logic       ptr_last;
        logic       shift_done;
        logic       out_free;
    } lqs_sts_t;

endpackage

`default_nettype wire

### src/lqs_dp.sv
`default_nettype none
// Datapath: entry memory, head/tail/ptr counters, captured item, result register.
// Depends on lqs_pkg; driven by lqs_ctrl commands.

module lqs_dp
    import lqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lqs_item_t   item,
    input  wire lqs_cmd_t    cmd,
    output lqs_sts_t         sts,
    output logic             result_valid,
    input  wire logic        result_stall,
    output lqs_result_t      result
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic signed [31:0] mem_id      [QUEUE_DEPTH];
    logic [63:0]        mem_payload [QUEUE_DEPTH];

    lqs_item_t          item_reg;
    logic [CNT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   ptr_reg,  ptr_next;
    logic signed [31:0] rd_id_reg;
    logic [63:0]        rd_payload_reg;
    logic               out_valid_reg;
    lqs_result_t        out_reg;

    logic [CNT_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_id;
    logic [63:0]        wr_payload;
    logic [CNT_W-1:0]   ptr_plus1;
    logic [CNT_W-1:0]   live;
    logic               out_free;

    assign ptr_plus1 = ptr_reg + CNT_W'(1);
    assign live      = tail_reg - head_reg;
    assign out_free  = !out_valid_reg || !result_stall;

    assign sts.action     = item_reg.action;
    assign sts.empty      = (head_reg == tail_reg);
    assign sts.tail_full  = (tail_reg == DEPTH_C);
    assign sts.head_zero  = (head_reg == '0);
    assign sts.ptr_last   = (ptr_plus1 == tail_reg);
    assign sts.shift_done = (ptr_reg == live);
    assign sts.out_free   = out_free;

    always_comb
    begin
        case (cmd.rd_src)
            RD_HEAD:     rd_addr = head_reg;
            RD_PTR:      rd_addr = ptr_reg;
            RD_HEAD_PTR: rd_addr = head_reg + ptr_reg;
            default:     rd_addr = head_reg;
        endcase
    end

    // single write port: append or compaction move
    assign wr_en      = cmd.wr_tail || cmd.wr_ptr;
    assign wr_addr    = cmd.wr_tail ? tail_reg : ptr_reg;
    assign wr_id      = cmd.wr_tail ? item_reg.item_id : rd_id_reg;
    assign wr_payload = cmd.wr_tail ? item_reg.item_payload : rd_payload_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[wr_addr[ADDR_W-1:0]]      <= wr_id;
            mem_payload[wr_addr[ADDR_W-1:0]] <= wr_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_id_reg      <= mem_id[rd_addr[ADDR_W-1:0]];
            rd_payload_reg <= mem_payload[rd_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        ptr_next  = ptr_reg;
        if (cmd.compact)
        begin
            head_next = '0;
            tail_next = live;
        end
        if (cmd.head_inc)
        begin
            head_next = head_reg + CNT_W'(1);
        end
        if (cmd.wr_tail)
        begin
            tail_next = tail_reg + CNT_W'(1);
        end
        if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_head)
        begin
            ptr_next = head_reg;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_plus1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            ptr_reg  <= ptr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.status      <= cmd.out_status;
            out_reg.out_id      <= cmd.out_mem ? rd_id_reg : '0;
            out_reg.out_payload <= cmd.out_mem ? rd_payload_reg : '0;
            out_reg.last        <= cmd.out_last_ptr ? sts.ptr_last : 1'b1;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("head passed tail");

    a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= DEPTH_C)
        else $error("tail beyond queue depth");

    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compact |=> (head_reg == '0) && (tail_reg == $past(live)))
        else $error("compaction left wrong head or tail");

endmodule

`default_nettype wire

### src/lqs_ctrl.sv
`default_nettype none
// Controller state machine: sequences add, shift, delete and print.
// Depends on lqs_pkg; talks to lqs_dp through lqs_cmd_t / lqs_sts_t.

module lqs_ctrl
    import lqs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire lqs_sts_t sts,
    output lqs_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_APPEND    = 4'd2;
    localparam logic [3:0] S_APPEND_SH = 4'd3;
    localparam logic [3:0] S_SH_CHK    = 4'd4;
    localparam logic [3:0] S_SH_WR     = 4'd5;
    localparam logic [3:0] S_FULL      = 4'd6;
    localparam logic [3:0] S_EMPTY     = 4'd7;
    localparam logic [3:0] S_NOPRINT   = 4'd8;
    localparam logic [3:0] S_WRONG     = 4'd9;
    localparam logic [3:0] S_DEL_OUT   = 4'd10;
    localparam logic [3:0] S_PR_RD     = 4'd11;
    localparam logic [3:0] S_PR_OUT    = 4'd12;

    logic [3:0] state_reg, state_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_src = RD_HEAD;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.action)
                    ACT_ADD:
                    begin
                        if (!sts.tail_full)
                        begin
                            state_next = S_APPEND;
                        end
                        else if (sts.head_zero)
                        begin
                            state_next = S_FULL;
                        end
                        else
                        begin
                            cmd.ptr_clr = 1'b1;
                            state_next  = S_SH_CHK;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (sts.empty)
                        begin
                            state_next = S_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = RD_HEAD;
                            state_next = S_DEL_OUT;
                        end
                    end
                    ACT_PRINT:
                    begin
                        if (sts.empty)
                        begin
                            state_next = S_NOPRINT;
                        end
                        else
                        begin
                            cmd.ptr_head = 1'b1;
                            state_next   = S_PR_RD;
                        end
                    end
                    ACT_WRONG:
                    begin
                        state_next = S_WRONG;
                    end
                endcase
            end
            S_SH_CHK:
            begin
                if (sts.shift_done)
                begin
                    cmd.compact = 1'b1;
                    state_next  = S_APPEND_SH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_HEAD_PTR;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.wr_ptr  = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_SH_CHK;
            end
            S_APPEND, S_APPEND_SH:
            begin
                if (sts.out_free)
                begin
                    cmd.wr_tail    = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_status = (state_reg == S_APPEND) ? ST_ADDED : ST_SHIFTED;
                    state_next     = S_IDLE;
                end
            end
            S_FULL, S_EMPTY, S_NOPRINT, S_WRONG:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    case (state_reg)
                        S_FULL:    cmd.out_status = ST_FULL;
                        S_EMPTY:   cmd.out_status = ST_EMPTY;
                        S_NOPRINT: cmd.out_status = ST_NOPRINT;
                        default:   cmd.out_status = ST_WRONG;
                    endcase
                    state_next = S_IDLE;
                end
            end
            S_DEL_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_mem    = 1'b1;
                    cmd.out_status = ST_DELETED;
                    cmd.head_inc   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PR_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_PTR;
                state_next = S_PR_OUT;
            end
            S_PR_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_mem      = 1'b1;
                    cmd.out_last_ptr = 1'b1;
                    cmd.out_status   = ST_PRINT;
                    cmd.ptr_inc      = 1'b1;
                    state_next       = sts.ptr_last ? S_IDLE : S_PR_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### src/linear_queue_with_shift_unit.sv
`default_nettype none
// Top level of the linear array queue with compaction.
// Depends on lqs_pkg, lqs_ctrl and lqs_dp.
//
//   channel   direction  payload        handshake
//   item      in         lqs_item_t     item_valid / item_stall
//   result    out        lqs_result_t   result_valid / result_stall
//
// Per item: take, decode, then reply; a delete first reads the head entry,
// a print reads and replies for each live entry, and an add that compacts
// first moves each live entry through the single registered read port and single write port.
// Reset clears head, tail and control; the entry memory is not cleared and
// needs no pass, only written slots are ever read.
// A stalled result holds in the output register; the controller waits in
// its reply state until the register frees, and item_stall stays high
// until the current item's last result transfer is loaded.

module linear_queue_with_shift_unit
    import lqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire lqs_item_t   item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output lqs_result_t      result
);

    // command and status between controller and datapath
    lqs_cmd_t cmd;
    lqs_sts_t sts;

    lqs_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    lqs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
